// ===== rtl/core/cvs_pkg.sv =====
// ----------------------------------------------------------------------------
// cvs_pkg
// Shared types, register indexes and constants of the 3x3 convolution stream.
// ----------------------------------------------------------------------------
package cvs_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned KSIZE         = 3;
  localparam int unsigned PIX_W         = 8;
  localparam int unsigned COEFF_W       = 16;
  localparam int unsigned IMG_W_W       = 11;
  localparam int unsigned CREG_W        = COEFF_W * KSIZE;
  localparam int unsigned PROD_W        = COEFF_W + PIX_W + 1;
  localparam int unsigned SUM_W         = PROD_W + 4;
  localparam int unsigned QUO_W         = SUM_W - 8;
  localparam int unsigned FIFO_DEPTH    = 8;
  localparam int unsigned FIFO_AW       = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW       = $clog2(FIFO_DEPTH + 1);

  localparam logic [IMG_W_W-1:0] IMG_W_RST = IMG_W_W'(512);
  localparam logic [CREG_W-1:0]  COEFF_RST = 48'h001C_001C_001C;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH = 2'd0,
    REG_COEFF_ROW_0 = 2'd1,
    REG_COEFF_ROW_1 = 2'd2,
    REG_COEFF_ROW_2 = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             first_of_frame;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             clamped;
  } out_word_t;

  typedef logic [KSIZE-1:0][CREG_W-1:0] coeff_bank_t;

  // pixel and window flags of one accepted word, toward the line buffers
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             above1_ok;
    logic             above2_ok;
    logic             row_start;
  } tap_req_t;

  typedef logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] pix_win_t;

  typedef struct packed {
    logic     valid;
    pix_win_t pix;
  } tap_win_t;

endpackage

// ===== rtl/core/cvs_ctrl.sv =====
// ----------------------------------------------------------------------------
// cvs_ctrl
// Column and row tracking; yields the line address and window flags per word.
// ----------------------------------------------------------------------------
module cvs_ctrl #(
  parameter int unsigned MAX_WIDTH = cvs_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               acc,
  input  cvs_pkg::in_word_t                  in_word,
  input  logic [cvs_pkg::IMG_W_W-1:0]        image_width,
  output logic [$clog2(MAX_WIDTH)-1:0]       col,
  output cvs_pkg::tap_req_t                  req
);
  import cvs_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = CW + 1;

  logic [CW-1:0] col_r, col_nxt;
  logic [1:0]    rows_r, rows_nxt;
  logic [WW-1:0] eff_w;
  logic [CW-1:0] col_in;
  logic [1:0]    rows_in;
  logic [1:0]    rows_cur;
  logic [WW-1:0] col_inc;

  always_comb begin
    if (image_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width);
    end
  end

  always_comb begin
    col_in  = in_word.first_of_frame ? '0 : col_r;
    rows_in = in_word.first_of_frame ? '0 : rows_r;
    // width shrunk mid-row: close the row first
    if ({1'b0, col_in} >= eff_w) begin
      col      = '0;
      rows_cur = (rows_in == 2'd2) ? 2'd2 : rows_in + 2'd1;
    end else begin
      col      = col_in;
      rows_cur = rows_in;
    end
    col_inc = {1'b0, col} + WW'(1);
    if (col_inc >= eff_w) begin
      col_nxt  = '0;
      rows_nxt = (rows_cur == 2'd2) ? 2'd2 : rows_cur + 2'd1;
    end else begin
      col_nxt  = col_inc[CW-1:0];
      rows_nxt = rows_cur;
    end
    req.pix       = in_word.pixel_in;
    req.above1_ok = (rows_cur != 2'd0);
    req.above2_ok = (rows_cur == 2'd2);
    req.row_start = (col == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      rows_r <= '0;
    end else if (acc) begin
      col_r  <= col_nxt;
      rows_r <= rows_nxt;
    end
  end

endmodule

// ===== rtl/core/cvs_line_buf.sv =====
// ----------------------------------------------------------------------------
// cvs_line_buf
// Two line memories read at accept, written back next cycle, plus window.
// ----------------------------------------------------------------------------
module cvs_line_buf #(
  parameter int unsigned MAX_WIDTH = cvs_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         acc,
  input  logic [$clog2(MAX_WIDTH)-1:0] col,
  input  cvs_pkg::tap_req_t            req,
  output cvs_pkg::tap_win_t            win
);
  import cvs_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  logic [PIX_W-1:0] line1_mem [MAX_WIDTH];
  logic [PIX_W-1:0] line2_mem [MAX_WIDTH];

  logic [PIX_W-1:0] rd1_r, rd2_r;
  logic             b_valid_r;
  logic [CW-1:0]    b_col_r;
  tap_req_t         b_req_r;
  logic             fwd_r;
  logic [PIX_W-1:0] fwd1_r, fwd2_r;
  logic [PIX_W-1:0] win_r [6];

  logic [PIX_W-1:0] raw1, raw2, above1, above2;
  logic [PIX_W-1:0] pw [6];

  always_comb begin
    raw1   = fwd_r ? fwd1_r : rd1_r;
    raw2   = fwd_r ? fwd2_r : rd2_r;
    above1 = b_req_r.above1_ok ? raw1 : '0;
    above2 = b_req_r.above2_ok ? raw2 : '0;
    for (int i = 0; i < 6; i++) begin
      pw[i] = b_req_r.row_start ? '0 : win_r[i];
    end
    win.valid     = b_valid_r;
    win.pix[0][0] = b_req_r.pix;
    win.pix[0][1] = pw[0];
    win.pix[0][2] = pw[1];
    win.pix[1][0] = above1;
    win.pix[1][1] = pw[2];
    win.pix[1][2] = pw[3];
    win.pix[2][0] = above2;
    win.pix[2][1] = pw[4];
    win.pix[2][2] = pw[5];
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rd1_r   <= line1_mem[col];
      rd2_r   <= line2_mem[col];
      b_col_r <= col;
      b_req_r <= req;
      // same entry written back this edge: take the new data directly
      fwd1_r  <= b_req_r.pix;
      fwd2_r  <= above1;
    end
    if (b_valid_r) begin
      line1_mem[b_col_r] <= b_req_r.pix;
      line2_mem[b_col_r] <= above1;
      win_r[0] <= b_req_r.pix;
      win_r[1] <= pw[0];
      win_r[2] <= above1;
      win_r[3] <= pw[2];
      win_r[4] <= above2;
      win_r[5] <= pw[4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      fwd_r     <= 1'b0;
    end else begin
      b_valid_r <= acc;
      if (acc) begin
        fwd_r <= b_valid_r && (b_col_r == col);
      end
    end
  end

endmodule

// ===== rtl/core/cvs_mac.sv =====
// ----------------------------------------------------------------------------
// cvs_mac
// Nine products, registered sum, floor and clamp to an 8-bit result word.
// ----------------------------------------------------------------------------
module cvs_mac (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cvs_pkg::tap_win_t    win,
  input  cvs_pkg::coeff_bank_t coeff,
  output logic                 push,
  output cvs_pkg::out_word_t   res
);
  import cvs_pkg::*;

  logic                                   c_valid_r, d_valid_r;
  logic [KSIZE-1:0][KSIZE-1:0][PROD_W-1:0] prod_r;
  logic [SUM_W-1:0]                        sum_r;
  logic signed [SUM_W-1:0]                 sum_c;
  logic signed [QUO_W-1:0]                 quo;

  always_ff @(posedge clk) begin
    for (int m = 0; m < KSIZE; m++) begin
      for (int n = 0; n < KSIZE; n++) begin
        prod_r[m][n] <= PROD_W'($signed(coeff[m][COEFF_W*n +: COEFF_W])
                                * $signed({1'b0, win.pix[m][n]}));
      end
    end
    sum_r <= sum_c;
  end

  always_comb begin
    sum_c = '0;
    for (int m = 0; m < KSIZE; m++) begin
      for (int n = 0; n < KSIZE; n++) begin
        sum_c = sum_c + SUM_W'($signed(prod_r[m][n]));
      end
    end
  end

  // arithmetic shift floors toward minus infinity
  always_comb begin
    quo  = QUO_W'($signed(sum_r) >>> 8);
    push = d_valid_r;
    if (quo > $signed(QUO_W'(255))) begin
      res.pixel_out = 8'hFF;
      res.clamped   = 1'b1;
    end else if (quo < 0) begin
      res.pixel_out = '0;
      res.clamped   = 1'b1;
    end else begin
      res.pixel_out = quo[PIX_W-1:0];
      res.clamped   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
    end else begin
      c_valid_r <= win.valid;
      d_valid_r <= c_valid_r;
    end
  end

endmodule

// ===== rtl/core/cvs_out_fifo.sv =====
// ----------------------------------------------------------------------------
// cvs_out_fifo
// Result queue that decouples the free-running pipeline from out_ready.
// ----------------------------------------------------------------------------
module cvs_out_fifo (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  cvs_pkg::out_word_t                push_word,
  input  logic                              pop,
  output logic                              valid,
  output cvs_pkg::out_word_t                word,
  output logic [cvs_pkg::FIFO_CW-1:0]       count
);
  import cvs_pkg::*;

  out_word_t          fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] count_r;

  assign valid = (count_r != '0);
  assign word  = fifo_mem[rd_ptr_r];
  assign count = count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      count_r <= count_r + FIFO_CW'(push) - FIFO_CW'(pop);
    end
  end

endmodule

// ===== rtl/core/conv3x3_clamped_stream.sv =====
// ----------------------------------------------------------------------------
// conv3x3_clamped_stream
// 3x3 causal convolution on a raster pixel stream, Q8.8 taps, clamped output.
//
//   channel  ports                      word
//   in       in_valid/in_ready          in_word  {pixel_in, first_of_frame}
//   out      out_valid/out_ready        out_word {pixel_out, clamped}
//   cfg      cfg_we/cfg_index/cfg_wdata image_width, coeff_row_0..2
//
// One word per cycle in and out unless in_ready or out_ready is low. Rate is
// set by the line memories: one read at accept and one write-back in the next
// cycle per memory, with forwarding for the same column. Reset clears counters
// and queue and loads default config; line memories need no clearing pass. Up
// to 8 words may be in flight or queued; in_ready drops at that count.
// ----------------------------------------------------------------------------
module conv3x3_clamped_stream #(
  parameter int unsigned MAX_WIDTH = cvs_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  cvs_pkg::in_word_t           in_word,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cvs_pkg::out_word_t          out_word,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [cvs_pkg::CREG_W-1:0]  cfg_wdata
);
  import cvs_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  logic [IMG_W_W-1:0] image_width_r;
  coeff_bank_t        coeff_r;
  logic [FIFO_CW-1:0] credit_r, credit_nxt;
  logic               acc, pop, push;
  logic [CW-1:0]      col;
  tap_req_t           req;
  tap_win_t           win;
  out_word_t          res;
  logic [FIFO_CW-1:0] fifo_count;

  assign in_ready = (credit_r < FIFO_CW'(FIFO_DEPTH));
  assign acc      = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= IMG_W_RST;
      coeff_r       <= {KSIZE{COEFF_RST}};
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_IMAGE_WIDTH: image_width_r <= cfg_wdata[IMG_W_W-1:0];
        REG_COEFF_ROW_0: coeff_r[0]    <= cfg_wdata;
        REG_COEFF_ROW_1: coeff_r[1]    <= cfg_wdata;
        REG_COEFF_ROW_2: coeff_r[2]    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // words accepted and not yet taken at the output
  assign credit_nxt = credit_r + FIFO_CW'(acc) - FIFO_CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_nxt;
    end
  end

  cvs_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .in_word     (in_word),
    .image_width (image_width_r),
    .col         (col),
    .req         (req)
  );

  cvs_line_buf #(.MAX_WIDTH(MAX_WIDTH)) u_line_buf (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .col   (col),
    .req   (req),
    .win   (win)
  );

  cvs_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .win   (win),
    .coeff (coeff_r),
    .push  (push),
    .res   (res)
  );

  cvs_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (res),
    .pop       (pop),
    .valid     (out_valid),
    .word      (out_word),
    .count     (fifo_count)
  );

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= FIFO_CW'(FIFO_DEPTH))
    else $error("credit count above queue depth");

  a_queue_le_credit: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_count <= credit_r)
    else $error("queue holds more words than were accepted");

  a_accept_counts: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (credit_r != '0))
    else $error("accepted word not counted");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (credit_r == '0) && !out_valid)
    else $error("reset left words in flight");

endmodule

// ===== test/tb_conv3x3_clamped_stream.sv =====
// ----------------------------------------------------------------------------
// tb_conv3x3_clamped_stream
// Self-checking bench for the 3x3 clamped convolution stream. A shadow model
// of the line buffers, window and row counters predicts every output word.
// A short directed run covers the register extremes, clamping in both
// directions, frame starts and a width cut in the middle of a row. Random
// phases with fresh widths and taps follow, under changing handshake stalls.
// ----------------------------------------------------------------------------
module tb_conv3x3_clamped_stream;
  import cvs_pkg::*;

  localparam int unsigned RAND_WORDS = 1030;

  class conv_scoreboard;
    logic [IMG_W_W-1:0] img_width;
    logic [CREG_W-1:0]  coeff [KSIZE];
    logic [PIX_W-1:0]   line1 [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]   line2 [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]   win [KSIZE][2];
    int unsigned        col;
    int unsigned        rows;
    out_word_t          expected_q [$];
    int unsigned        fail_count;

    function new();
      img_width = IMG_W_RST;
      foreach (coeff[m]) coeff[m] = COEFF_RST;
      foreach (line1[i]) begin
        line1[i] = '0;
        line2[i] = '0;
      end
      foreach (win[m, n]) win[m][n] = '0;
      col = 0;
      rows = 0;
      fail_count = 0;
    endfunction

    function int unsigned eff_width();
      if (img_width == 0) return 1;
      if (img_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return img_width;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void next_row();
      col = 0;
      if (rows < 2) rows++;
      foreach (win[m, n]) win[m][n] = '0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CREG_W-1:0] v);
      case (idx)
        REG_IMAGE_WIDTH: img_width = v[IMG_W_W-1:0];
        REG_COEFF_ROW_0: coeff[0] = v;
        REG_COEFF_ROW_1: coeff[1] = v;
        REG_COEFF_ROW_2: coeff[2] = v;
        default: ;
      endcase
    endfunction

    function void note_pixel(in_word_t w);
      int unsigned      wd;
      logic [PIX_W-1:0] up1;
      logic [PIX_W-1:0] up2;
      logic [PIX_W-1:0] px [KSIZE][KSIZE];
      longint           acc;
      longint           q;
      out_word_t        want;
      if (w.first_of_frame) begin
        col = 0;
        rows = 0;
        foreach (win[m, n]) win[m][n] = '0;
      end
      wd = eff_width();
      if (col >= wd) next_row();
      up1 = (rows >= 1) ? line1[col] : '0;
      up2 = (rows >= 2) ? line2[col] : '0;
      px[0][0] = w.pixel_in;
      px[1][0] = up1;
      px[2][0] = up2;
      for (int m = 0; m < KSIZE; m++) begin
        px[m][1] = win[m][0];
        px[m][2] = win[m][1];
      end
      acc = 0;
      for (int m = 0; m < KSIZE; m++)
        for (int n = 0; n < KSIZE; n++)
          acc += longint'($signed(coeff[m][COEFF_W*n +: COEFF_W])) * longint'(px[m][n]);
      // arithmetic shift floors toward minus infinity
      q = acc >>> 8;
      if (q > 255) begin
        want.pixel_out = '1;
        want.clamped   = 1'b1;
      end else if (q < 0) begin
        want.pixel_out = '0;
        want.clamped   = 1'b1;
      end else begin
        want.pixel_out = PIX_W'(q);
        want.clamped   = 1'b0;
      end
      expected_q.push_back(want);
      line2[col] = up1;
      line1[col] = w.pixel_in;
      for (int m = 0; m < KSIZE; m++) win[m][1] = win[m][0];
      win[0][0] = w.pixel_in;
      win[1][0] = up1;
      win[2][0] = up2;
      col++;
      if (col >= wd) next_row();
    endfunction

    function void check_pixel(out_word_t got);
      out_word_t want;
      if (expected_q.size() == 0) begin
        fail_count++;
        $error("output word %0h with nothing expected", got);
        return;
      end
      want = expected_q.pop_front();
      if (got.pixel_out !== want.pixel_out) begin
        fail_count++;
        $error("pixel_out expected %0d actual %0d", want.pixel_out, got.pixel_out);
      end
      if (got.clamped !== want.clamped) begin
        fail_count++;
        $error("clamped expected %0d actual %0d", want.clamped, got.clamped);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_word_t          in_word = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_word_t         out_word;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [CREG_W-1:0] cfg_wdata = '0;

  int unsigned    send_idle = 35;
  int unsigned    recv_idle = 86;
  conv_scoreboard sb = new();

  conv3x3_clamped_stream dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_pixel(in_word);
    if (rst_n && out_valid && out_ready) sb.check_pixel(out_word);
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [PIX_W-1:0] pick_pixel();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 30) return '1;
    return PIX_W'($urandom);
  endfunction

  function automatic logic [COEFF_W-1:0] rand_tap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return '0;
    if (r < 55) return COEFF_W'($urandom_range(120)) - COEFF_W'(40);
    if (r < 70) return COEFF_W'($urandom);
    case ($urandom_range(3))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  function automatic logic [IMG_W_W-1:0] pick_width();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) return '0;
    if (r < 8) return IMG_W_W'(1);
    if (r < 11) return '1;
    if (r < 13) return IMG_W_W'(MAX_WIDTH_DEF);
    if (r < 15) return IMG_W_W'(MAX_WIDTH_DEF + 1);
    if (r < 85) return IMG_W_W'($urandom_range(12, 2));
    return IMG_W_W'($urandom_range(80, 13));
  endfunction

  task automatic send_word(input logic [PIX_W-1:0] pix, input logic sof);
    in_valid <= 1'b1;
    in_word  <= '{pixel_in: pix, first_of_frame: sof};
    do @(posedge clk); while (!in_ready);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CREG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic reshuffle_config();
    logic [CREG_W-1:0] v;
    if ($urandom_range(99) < 70) begin
      // junk above the width field must be ignored
      v = CREG_W'({$urandom, $urandom});
      v[IMG_W_W-1:0] = pick_width();
      write_reg(REG_IMAGE_WIDTH, v);
    end
    for (int r = 0; r < KSIZE; r++) begin
      if ($urandom_range(1) == 1)
        write_reg(reg_idx_t'(REG_COEFF_ROW_0 + r), {rand_tap(), rand_tap(), rand_tap()});
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned n_rand;
    int unsigned old_w;
    int unsigned len;
    logic        fresh;
    logic        sof;
    n_rand = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset taps and width, three words of a frame
    send_word(8'd255, 1'b1);
    send_word(8'd0, 1'b0);
    send_word(8'd128, 1'b0);

    // width cut below the current column ends the row early
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, CREG_W'(2));
    write_reg(REG_COEFF_ROW_0, COEFF_RST);
    cfg_we <= 1'b0;
    repeat (6) send_word(8'd255, 1'b0);
    send_word(8'd0, 1'b0);
    send_word(8'd1, 1'b0);

    // width zero acts as one; extreme taps clamp both ways
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, CREG_W'(0));
    write_reg(REG_COEFF_ROW_0, 48'h7FFF_7FFF_7FFF);
    write_reg(REG_COEFF_ROW_1, 48'h8000_8000_8000);
    write_reg(REG_COEFF_ROW_2, 48'hFFFF_FFFF_FFFF);
    cfg_we <= 1'b0;
    send_word(8'd255, 1'b0);
    send_word(8'd0, 1'b0);
    send_word(8'd0, 1'b0);
    send_word(8'd1, 1'b0);
    send_word(8'd0, 1'b0);

    // widest setting, small negative sums floor to minus one
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, CREG_W'(2047));
    write_reg(REG_COEFF_ROW_0, 48'h0000_0000_FFFF);
    write_reg(REG_COEFF_ROW_1, '0);
    write_reg(REG_COEFF_ROW_2, '0);
    cfg_we <= 1'b0;
    send_word(8'd1, 1'b1);
    send_word(8'd0, 1'b0);
    send_word(8'd255, 1'b0);

    while (n_rand < RAND_WORDS) begin
      if (n_rand < RAND_WORDS / 3) begin
        send_idle = 35;
        recv_idle = 86;
      end else if (n_rand < 2 * RAND_WORDS / 3) begin
        send_idle = 86;
        recv_idle = 35;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      wait_drained();
      old_w = sb.eff_width();
      reshuffle_config();
      // a wider row would reach line entries never written in this frame
      fresh = (sb.eff_width() > old_w);
      len = $urandom_range(60, 6);
      for (int i = 0; i < len; i++) begin
        sof = (i == 0 && (fresh || $urandom_range(3) == 0)) || ($urandom_range(99) < 2);
        if (i == len / 2 && $urandom_range(7) == 0) wait_drained();
        send_word(pick_pixel(), sof);
        n_rand++;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
